/* hdl/dbhl_pkg.sv */
// dbhl_pkg: widths, register codes and item types shared by the height lookup block
// no dependencies; compiled first
`default_nettype none

package dbhl_pkg;

    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 256;

    localparam int HEIGHT_W   = 24;
    localparam int QUERY_W    = 32;
    localparam int RECIP_W    = 24;
    localparam int DIM_W      = 9;
    localparam int IDX_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int SCALED_W = QUERY_W + RECIP_W;
    localparam int CELL_W   = SCALED_W - 2 * FRAC_W;
    localparam int WEIGHT_W = FRAC_W + 1;
    localparam int WPROD_W  = 2 * FRAC_W + 1;
    localparam int TERM_W   = WPROD_W + HEIGHT_W + 1;
    localparam int SUM_W    = TERM_W + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;

    localparam logic [DIM_W-1:0]    RST_DIM    = DIM_W'(256);
    localparam logic [RECIP_W-1:0]  RST_RECIP  = RECIP_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [SUM_W-1:0]    ROUND_BIAS =
        {{(SUM_W - 2 * FRAC_W){1'b0}}, 1'b1, {(2 * FRAC_W - 1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COLS = 2'd0,
        REG_NUM_ROWS = 2'd1,
        REG_RECIP_EW = 2'd2,
        REG_RECIP_NS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                       is_query;
        logic                       wr_ok;
        logic                       oor;
        logic                       has_r;
        logic                       has_d;
        logic [FRAC_W-1:0]          fa;
        logic [FRAC_W-1:0]          fb;
        logic signed [HEIGHT_W-1:0] height;
    } q_ctl_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_out;
        logic                       out_of_range;
    } res_item_t;

endpackage

`default_nettype wire

/* hdl/dbhl_if.sv */
// dbhl interfaces: request, result and configuration channels
// depends on dbhl_pkg
`default_nettype none

interface dbhl_req_if import dbhl_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [IDX_W-1:0]           cell_index;
    logic signed [HEIGHT_W-1:0] load_height;
    logic [QUERY_W-1:0]         query_x;
    logic [QUERY_W-1:0]         query_y;

    modport source (
        output valid, req_type, cell_index, load_height, query_x, query_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, cell_index, load_height, query_x, query_y,
        output ready
    );
endinterface

interface dbhl_res_if import dbhl_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [HEIGHT_W-1:0] height_out;
    logic                       out_of_range;

    modport source (
        output valid, height_out, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, height_out, out_of_range,
        output ready
    );
endinterface

interface dbhl_cfg_if import dbhl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/dem_bilinear_height_lookup.sv */
// dem_bilinear_height_lookup: elevation grid with bilinear height lookup, top level
// depends on dbhl_pkg, dbhl_if, dbhl_fifo, dbhl_front and dbhl_back
//
// usage:
//   req: one item per handshake; req_type 0 stores load_height at cell_index
//   (ignored past the grid storage), req_type 1 asks for the height at
//   (query_x, query_y). loads give no result, each query gives one on res.
//   cfg: writes num_cols, num_rows, recip_ew_res, recip_ns_res by index;
//   always ready; the user must write them only while no item is in flight,
//   which the block does not enforce.
//   throughput: one item per cycle while req.ready is high; loads and queries
//   mix freely. path: front scaling register, middle queue, then in the back
//   part corner reads with weight products, weighted terms and pair sums.
//   stall: results wait in a four-entry output queue; once it has no room for
//   the results in flight the back part stops draining the four-entry middle
//   queue, and req.ready falls once it and the front stage hold four items.
//   reset: all queues and stages empty, registers at 256, 256, 1.0, 1.0;
//   grid contents undefined until loaded, no clearing pass.
`default_nettype none

module dem_bilinear_height_lookup import dbhl_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic       clk,
    input  logic       rst_n,
    dbhl_req_if.sink   req,
    dbhl_res_if.source res,
    dbhl_cfg_if.sink   cfg
);

    localparam int CIW     = $clog2(MAX_COLS);
    localparam int RIW     = $clog2(MAX_ROWS);
    localparam int CNT_C_W = $clog2(MAX_COLS + 1);
    localparam int CNT_R_W = $clog2(MAX_ROWS + 1);
    localparam int ROW_W   = RIW + CNT_C_W;
    localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
    localparam int QW      = $bits(q_ctl_t) + CIW + ROW_W;

    logic [DIM_W-1:0]   num_cols_reg;
    logic [DIM_W-1:0]   num_rows_reg;
    logic [RECIP_W-1:0] recip_ew_reg;
    logic [RECIP_W-1:0] recip_ns_reg;
    logic [31:0]        num_cols_ext;
    logic [31:0]        num_rows_ext;
    logic [CNT_C_W-1:0] cols_used;
    logic [CNT_R_W-1:0] rows_used;

    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    logic [QCW-1:0]     q_count;
    q_ctl_t             f_ctl;
    logic [CIW-1:0]     f_ci;
    logic [ROW_W-1:0]   f_row_off;
    q_ctl_t             b_ctl;
    logic [CIW-1:0]     b_ci;
    logic [ROW_W-1:0]   b_row_off;
    logic [QW-1:0]      q_in;
    logic [QW-1:0]      q_out;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= RST_DIM;
            num_rows_reg <= RST_DIM;
            recip_ew_reg <= RST_RECIP;
            recip_ns_reg <= RST_RECIP;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_NUM_COLS: num_cols_reg <= cfg.data[DIM_W-1:0];
                REG_NUM_ROWS: num_rows_reg <= cfg.data[DIM_W-1:0];
                REG_RECIP_EW: recip_ew_reg <= cfg.data[RECIP_W-1:0];
                REG_RECIP_NS: recip_ns_reg <= cfg.data[RECIP_W-1:0];
                default:      num_cols_reg <= num_cols_reg;
            endcase
        end
    end

    // dimensions in use, limited by storage
    assign num_cols_ext = 32'(num_cols_reg);
    assign num_rows_ext = 32'(num_rows_reg);
    assign cols_used    = (num_cols_ext < 32'(MAX_COLS))
                          ? num_cols_ext[CNT_C_W-1:0] : CNT_C_W'(MAX_COLS);
    assign rows_used    = (num_rows_ext < 32'(MAX_ROWS))
                          ? num_rows_ext[CNT_R_W-1:0] : CNT_R_W'(MAX_ROWS);

    dbhl_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cols_used (cols_used),
        .rows_used (rows_used),
        .recip_ew  (recip_ew_reg),
        .recip_ns  (recip_ns_reg),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_ctl     (f_ctl),
        .q_ci      (f_ci),
        .q_row_off (f_row_off)
    );

    assign q_in = {f_ctl, f_ci, f_row_off};

    dbhl_fifo #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .count     (q_count)
    );

    assign {b_ctl, b_ci, b_row_off} = q_out;

    dbhl_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_ctl     (b_ctl),
        .q_ci      (b_ci),
        .q_row_off (b_row_off),
        .q_pop     (q_pop),
        .cols_used (cols_used),
        .res       (res)
    );

endmodule

`default_nettype wire

/* hdl/dbhl_fifo.sv */
// dbhl_fifo: small synchronous fifo with occupancy count
// used as the front-to-back queue and as the result queue; no dependencies
`default_nettype none

module dbhl_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [W-1:0]               push_data,
    input  logic                       pop,
    output logic [W-1:0]               pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  store [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = store[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

`default_nettype wire

/* hdl/dbhl_front.sv */
// dbhl_front: accepts requests, scales query coordinates and classifies each item
// depends on dbhl_pkg and dbhl_if; feeds the queue in front of dbhl_back
`default_nettype none

module dbhl_front import dbhl_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    dbhl_req_if.sink                               req,
    input  logic [$clog2(MAX_COLS+1)-1:0]          cols_used,
    input  logic [$clog2(MAX_ROWS+1)-1:0]          rows_used,
    input  logic [RECIP_W-1:0]                     recip_ew,
    input  logic [RECIP_W-1:0]                     recip_ns,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]       q_count,
    output logic                                   q_push,
    output q_ctl_t                                 q_ctl,
    output logic [$clog2(MAX_COLS)-1:0]            q_ci,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS+1)-1:0] q_row_off
);

    localparam int CIW     = $clog2(MAX_COLS);
    localparam int RIW     = $clog2(MAX_ROWS);
    localparam int CNT_C_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W   = RIW + CNT_C_W;
    localparam int DEPTH   = MAX_COLS * MAX_ROWS;
    localparam int AW      = $clog2(DEPTH);

    logic                       accept;
    logic                       v1_reg;
    logic                       req_type_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic signed [HEIGHT_W-1:0] hgt_reg;
    logic [SCALED_W-1:0]        sx_reg;
    logic [SCALED_W-1:0]        sy_reg;

    logic [CELL_W-1:0]          ci;
    logic [CELL_W-1:0]          rj;
    logic [CIW-1:0]             ci_low;
    logic [RIW-1:0]             rj_low;
    logic [AW+IDX_W-1:0]        idx_wide;
    logic [ROW_W-1:0]           row_prod;

    assign req.ready = (32'(q_count) + 32'(v1_reg)) < 32'(QUEUE_DEPTH);
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    // coordinate scaling: q16.16 times q8.16
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            idx_reg      <= req.cell_index;
            hgt_reg      <= req.load_height;
            sx_reg       <= SCALED_W'(req.query_x) * SCALED_W'(recip_ew);
            sy_reg       <= SCALED_W'(req.query_y) * SCALED_W'(recip_ns);
        end
    end

    assign ci       = sx_reg[SCALED_W-1 -: CELL_W];
    assign rj       = sy_reg[SCALED_W-1 -: CELL_W];
    assign ci_low   = ci[CIW-1:0];
    assign rj_low   = rj[RIW-1:0];
    assign idx_wide = (AW + IDX_W)'(idx_reg);
    assign row_prod = ROW_W'(rj_low) * ROW_W'(cols_used);

    always_comb
    begin
        q_ctl.is_query = req_type_reg;
        q_ctl.wr_ok    = 32'(idx_reg) < 32'(DEPTH);
        q_ctl.oor      = (ci >= CELL_W'(cols_used)) || (rj >= CELL_W'(rows_used));
        q_ctl.has_r    = (32'(ci_low) + 32'd1) < 32'(cols_used);
        q_ctl.has_d    = (32'(rj_low) + 32'd1) < 32'(rows_used);
        q_ctl.fa       = sx_reg[2*FRAC_W-1 -: FRAC_W];
        q_ctl.fb       = sy_reg[2*FRAC_W-1 -: FRAC_W];
        q_ctl.height   = hgt_reg;
        // loads reuse the address path: column zero plus the linear index
        if (req_type_reg)
        begin
            q_ci      = ci_low;
            q_row_off = row_prod;
        end
        else
        begin
            q_ci      = '0;
            q_row_off = ROW_W'(idx_wide[AW-1:0]);
        end
    end

    assign q_push = v1_reg;

endmodule

`default_nettype wire

/* hdl/dbhl_back.sv */
// dbhl_back: grid memory, corner fetch, weighting and rounding, result queue
// depends on dbhl_pkg, dbhl_if and dbhl_fifo; drains the queue fed by dbhl_front
`default_nettype none

module dbhl_back import dbhl_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_empty,
    input  q_ctl_t                                 q_ctl,
    input  logic [$clog2(MAX_COLS)-1:0]            q_ci,
    input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS+1)-1:0] q_row_off,
    output logic                                   q_pop,
    input  logic [$clog2(MAX_COLS+1)-1:0]          cols_used,
    dbhl_res_if.source                             res
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = AW + 2;
    localparam int OCW   = $clog2(OUT_DEPTH + 1);

    logic signed [HEIGHT_W-1:0] mem_top [DEPTH];
    logic signed [HEIGHT_W-1:0] mem_bot [DEPTH];

    logic            pop_ok;
    logic            do_q;
    logic            do_w;
    logic [SW-1:0]   base;
    logic [SW-1:0]   base_r;
    logic [SW-1:0]   base_d;
    logic [SW-1:0]   base_dr;
    logic [AW-1:0]   a0;
    logic [AW-1:0]   a1;
    logic [AW-1:0]   a2;
    logic [AW-1:0]   a3;
    logic [WEIGHT_W-1:0] wa0;
    logic [WEIGHT_W-1:0] wb0;
    logic [WEIGHT_W-1:0] wa1;
    logic [WEIGHT_W-1:0] wb1;

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic                       oor1_reg;
    logic                       oor2_reg;
    logic                       oor3_reg;
    logic                       hr1_reg;
    logic                       hd1_reg;
    logic [WPROD_W-1:0]         w0_reg;
    logic [WPROD_W-1:0]         w1_reg;
    logic [WPROD_W-1:0]         w2_reg;
    logic [WPROD_W-1:0]         w3_reg;
    logic signed [HEIGHT_W-1:0] h0_reg;
    logic signed [HEIGHT_W-1:0] h1_reg;
    logic signed [HEIGHT_W-1:0] h2_reg;
    logic signed [HEIGHT_W-1:0] h3_reg;
    logic signed [TERM_W-1:0]   t0_reg;
    logic signed [TERM_W-1:0]   t1_reg;
    logic signed [TERM_W-1:0]   t2_reg;
    logic signed [TERM_W-1:0]   t3_reg;
    logic signed [SUM_W-1:0]    s01_reg;
    logic signed [SUM_W-1:0]    s23_reg;
    logic signed [SUM_W-1:0]    total;

    logic            o_push;
    logic            o_pop;
    logic            o_empty;
    logic [OCW-1:0]  o_count;
    res_item_t       o_in;
    res_item_t       o_out;

    // room in the result queue for everything already in the datapath
    assign o_pop  = res.valid && res.ready;
    assign pop_ok = (32'(o_count) - 32'(o_pop) + 32'(v1_reg) + 32'(v2_reg) + 32'(v3_reg))
                    < 32'(OUT_DEPTH);
    assign q_pop  = !q_empty && pop_ok;
    assign do_q   = q_pop && q_ctl.is_query;
    assign do_w   = q_pop && !q_ctl.is_query && q_ctl.wr_ok;

    // corner addresses
    assign base    = SW'(q_ci) + SW'(q_row_off);
    assign base_r  = base + SW'(1);
    assign base_d  = base + SW'(cols_used);
    assign base_dr = base_d + SW'(1);
    assign a0      = base[AW-1:0];
    assign a1      = base_r[AW-1:0];
    assign a2      = base_d[AW-1:0];
    assign a3      = base_dr[AW-1:0];

    assign wa1 = WEIGHT_W'(q_ctl.fa);
    assign wb1 = WEIGHT_W'(q_ctl.fb);
    assign wa0 = WEIGHT_ONE - wa1;
    assign wb0 = WEIGHT_ONE - wb1;

    // two copies of the grid, two read ports each
    always_ff @(posedge clk)
    begin
        if (do_w)
        begin
            mem_top[a0] <= q_ctl.height;
        end
        if (do_q)
        begin
            h0_reg <= mem_top[a0];
            h1_reg <= mem_top[a1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_w)
        begin
            mem_bot[a0] <= q_ctl.height;
        end
        if (do_q)
        begin
            h2_reg <= mem_bot[a2];
            h3_reg <= mem_bot[a3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= do_q;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_q)
        begin
            oor1_reg <= q_ctl.oor;
            hr1_reg  <= q_ctl.has_r;
            hd1_reg  <= q_ctl.has_d;
            w0_reg   <= WPROD_W'(wa0) * WPROD_W'(wb0);
            w1_reg   <= WPROD_W'(wa1) * WPROD_W'(wb0);
            w2_reg   <= WPROD_W'(wa0) * WPROD_W'(wb1);
            w3_reg   <= WPROD_W'(wa1) * WPROD_W'(wb1);
        end
    end

    // weighted corners; neighbours past the edge drop out
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            oor2_reg <= oor1_reg;
            t0_reg   <= TERM_W'($signed({1'b0, w0_reg})) * TERM_W'(h0_reg);
            t1_reg   <= hr1_reg
                        ? TERM_W'($signed({1'b0, w1_reg})) * TERM_W'(h1_reg) : '0;
            t2_reg   <= hd1_reg
                        ? TERM_W'($signed({1'b0, w2_reg})) * TERM_W'(h2_reg) : '0;
            t3_reg   <= (hr1_reg && hd1_reg)
                        ? TERM_W'($signed({1'b0, w3_reg})) * TERM_W'(h3_reg) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            oor3_reg <= oor2_reg;
            s01_reg  <= SUM_W'(t0_reg) + SUM_W'(t1_reg);
            s23_reg  <= SUM_W'(t2_reg) + SUM_W'(t3_reg) + ROUND_BIAS;
        end
    end

    // round half up: bias already added, floor by taking the upper bits
    assign total = s01_reg + s23_reg;

    always_comb
    begin
        o_in.out_of_range = oor3_reg;
        o_in.height_out   = oor3_reg ? '0 : total[2*FRAC_W +: HEIGHT_W];
    end

    assign o_push = v3_reg;

    dbhl_fifo #(
        .W     ($bits(res_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (o_push),
        .push_data (o_in),
        .pop       (o_pop),
        .pop_data  (o_out),
        .empty     (o_empty),
        .count     (o_count)
    );

    assign res.valid        = !o_empty;
    assign res.height_out   = o_out.height_out;
    assign res.out_of_range = o_out.out_of_range;

endmodule

`default_nettype wire

/* hdl/dbhl_checker.sv */
// dbhl_checker: port-level checks on the height lookup block, bound to the top level
// depends on dbhl_pkg; sees only the top-level ports
`default_nettype none

module dbhl_checker import dbhl_pkg::*; (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       req_type,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic signed [HEIGHT_W-1:0] height_out,
    input logic                       out_of_range
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       q_acc;
    logic       r_acc;

    assign q_acc = req_valid && req_ready && req_type;
    assign r_acc = res_valid && res_ready;

    always_comb
    begin
        pending_next = pending_reg + 8'(q_acc) - 8'(r_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_of_range |-> height_out == '0)
        else $error("out of range result with nonzero height");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != '0)
        else $error("result without a pending query");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before taken");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(height_out) && $stable(out_of_range))
        else $error("stalled result changed");

endmodule

bind dem_bilinear_height_lookup dbhl_checker u_dbhl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_type     (req.req_type),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .height_out   (res.height_out),
    .out_of_range (res.out_of_range)
);

`default_nettype wire
